[hdl/sync_frame_parser_fletcher_check_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sync frame parser
// Shared property forms used by the parser control module of this block.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_PARSER_FLETCHER_CHECK_TOP_MACROS_SVH
`define SYNC_FRAME_PARSER_FLETCHER_CHECK_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SFP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define SFP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/sfp_pkg.sv]
// ----------------------------------------------------------------------------
// Sync frame parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int BYTE_W = 8;
    localparam int SIZE_W = 7;
    localparam int IDX_W  = 6;
    localparam int CFG_AW = 3;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] RST_KIND_A_ID   = 8'd16;
    localparam logic [SIZE_W-1:0] RST_KIND_A_SIZE = 7'd58;
    localparam logic [BYTE_W-1:0] RST_KIND_B_ID   = 8'd32;
    localparam logic [SIZE_W-1:0] RST_KIND_B_SIZE = 7'd6;
    localparam logic [BYTE_W-1:0] RST_KIND_C_ID   = 8'd48;
    localparam logic [SIZE_W-1:0] RST_KIND_C_SIZE = 7'd12;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_KIND_A_ID   = 3'd0,
        CFG_KIND_A_SIZE = 3'd1,
        CFG_KIND_B_ID   = 3'd2,
        CFG_KIND_B_SIZE = 3'd3,
        CFG_KIND_C_ID   = 3'd4,
        CFG_KIND_C_SIZE = 3'd5
    } t_cfg_reg;

    // Parser phases
    typedef enum logic [3:0] {
        PH_HUNT  = 4'd0,
        PH_SYNC2 = 4'd1,
        PH_ID    = 4'd2,
        PH_LEN   = 4'd3,
        PH_PAY   = 4'd4,
        PH_SUM1  = 4'd5,
        PH_SUM2  = 4'd6,
        PH_RD    = 4'd7,
        PH_LOAD  = 4'd8
    } t_phase;

endpackage

[hdl/sfp_store.sv]
// ----------------------------------------------------------------------------
// Frame payload store
// Single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
module sfp_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [sfp_pkg::BYTE_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [sfp_pkg::BYTE_W-1:0] o_rdata
);

    logic [sfp_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [sfp_pkg::BYTE_W-1:0] r_rdata;

    // Write payload bytes
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/sfp_cfg.sv]
// ----------------------------------------------------------------------------
// Frame kind registers
// Holds the three id/size pairs and checks a received length against them.
// ----------------------------------------------------------------------------
module sfp_cfg #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [sfp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [sfp_pkg::BYTE_W-1:0] i_cfg_wdata,
    input  logic [sfp_pkg::BYTE_W-1:0] i_id,
    input  logic [sfp_pkg::BYTE_W-1:0] i_len,
    output logic                       o_len_ok
);

    localparam logic [8:0] MaxP = 9'(MAX_PAYLOAD);

    logic [sfp_pkg::BYTE_W-1:0] r_a_id, r_b_id, r_c_id;
    logic [sfp_pkg::SIZE_W-1:0] r_a_size, r_b_size, r_c_size;
    logic                       a_ok, b_ok, c_ok;

    // Write registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_id   <= sfp_pkg::RST_KIND_A_ID;
            r_a_size <= sfp_pkg::RST_KIND_A_SIZE;
            r_b_id   <= sfp_pkg::RST_KIND_B_ID;
            r_b_size <= sfp_pkg::RST_KIND_B_SIZE;
            r_c_id   <= sfp_pkg::RST_KIND_C_ID;
            r_c_size <= sfp_pkg::RST_KIND_C_SIZE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                sfp_pkg::CFG_KIND_A_ID:   r_a_id   <= i_cfg_wdata;
                sfp_pkg::CFG_KIND_A_SIZE: r_a_size <= i_cfg_wdata[sfp_pkg::SIZE_W-1:0];
                sfp_pkg::CFG_KIND_B_ID:   r_b_id   <= i_cfg_wdata;
                sfp_pkg::CFG_KIND_B_SIZE: r_b_size <= i_cfg_wdata[sfp_pkg::SIZE_W-1:0];
                sfp_pkg::CFG_KIND_C_ID:   r_c_id   <= i_cfg_wdata;
                sfp_pkg::CFG_KIND_C_SIZE: r_c_size <= i_cfg_wdata[sfp_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Match id and size; a zero or oversized size never matches
    assign a_ok = (r_a_id == i_id) && ({1'b0, r_a_size} == i_len) && (r_a_size != '0)
                  && ({2'b00, r_a_size} <= MaxP);
    assign b_ok = (r_b_id == i_id) && ({1'b0, r_b_size} == i_len) && (r_b_size != '0)
                  && ({2'b00, r_b_size} <= MaxP);
    assign c_ok = (r_c_id == i_id) && ({1'b0, r_c_size} == i_len) && (r_c_size != '0)
                  && ({2'b00, r_c_size} <= MaxP);

    assign o_len_ok = a_ok || b_ok || c_ok;

endmodule

[hdl/sfp_ctrl.sv]
// ----------------------------------------------------------------------------
// Frame parser control
// Sync hunt, header and payload capture, checksum test and payload readout.
// ----------------------------------------------------------------------------
module sfp_ctrl #(
    parameter int AW = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // byte input
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [sfp_pkg::BYTE_W-1:0] i_rx_byte,
    // kind check
    output logic [sfp_pkg::BYTE_W-1:0] o_cur_id,
    input  logic                       i_len_ok,
    // store access
    output logic                       o_mem_we,
    output logic [AW-1:0]              o_mem_waddr,
    output logic [sfp_pkg::BYTE_W-1:0] o_mem_wdata,
    output logic                       o_mem_re,
    output logic [AW-1:0]              o_mem_raddr,
    input  logic [sfp_pkg::BYTE_W-1:0] i_mem_rdata,
    // result output
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sfp_pkg::BYTE_W-1:0] o_frame_id,
    output logic [sfp_pkg::IDX_W-1:0]  o_byte_index,
    output logic [sfp_pkg::BYTE_W-1:0] o_payload_byte,
    output logic                       o_last_byte
);

    `include "sync_frame_parser_fletcher_check_top_macros.svh"

    sfp_pkg::t_phase              r_phase, n_phase;
    logic [sfp_pkg::SIZE_W-1:0]   r_count, n_count;
    logic [sfp_pkg::SIZE_W-1:0]   r_rd_idx, n_rd_idx;
    logic [sfp_pkg::BYTE_W-1:0]   r_id, n_id;
    logic [sfp_pkg::SIZE_W-1:0]   r_length, n_length;
    logic [sfp_pkg::BYTE_W-1:0]   r_sum_one, n_sum_one;
    logic [sfp_pkg::BYTE_W-1:0]   r_sum_two, n_sum_two;
    logic                         r_out_valid, n_out_valid;
    logic [sfp_pkg::BYTE_W-1:0]   r_out_id;
    logic [sfp_pkg::IDX_W-1:0]    r_out_idx;
    logic [sfp_pkg::BYTE_W-1:0]   r_out_byte;
    logic                         r_out_last;
    logic                         in_acc;
    logic                         slot_free;
    logic                         load;
    logic                         rd_last;
    logic [sfp_pkg::BYTE_W-1:0]   sum_one_add;
    logic [7:0]                   cnt_inc;
    logic [7:0]                   rd_inc;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign load        = (r_phase == sfp_pkg::PH_LOAD) && slot_free;
    assign sum_one_add = r_sum_one + i_rx_byte;
    assign cnt_inc     = {1'b0, r_count} + 8'd1;
    assign rd_inc      = {1'b0, r_rd_idx} + 8'd1;
    assign rd_last     = (rd_inc == {1'b0, r_length});

    // Next phase, sums and store access
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_rd_idx    = r_rd_idx;
        n_id        = r_id;
        n_length    = r_length;
        n_sum_one   = r_sum_one;
        n_sum_two   = r_sum_two;
        n_out_valid = r_out_valid && i_out_stall;
        o_in_stall  = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        unique case (r_phase)
            sfp_pkg::PH_HUNT: begin
                if (in_acc) begin
                    n_phase = (i_rx_byte == sfp_pkg::SYNC_FIRST) ? sfp_pkg::PH_SYNC2
                                                                 : sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_SYNC2: begin
                if (in_acc) begin
                    if (i_rx_byte == sfp_pkg::SYNC_SECOND) begin
                        n_sum_one = '0;
                        n_sum_two = '0;
                        n_phase   = sfp_pkg::PH_ID;
                    end else begin
                        n_phase = sfp_pkg::PH_HUNT;
                    end
                end
            end
            sfp_pkg::PH_ID: begin
                if (in_acc) begin
                    n_id      = i_rx_byte;
                    n_sum_one = sum_one_add;
                    n_sum_two = r_sum_two + sum_one_add;
                    n_phase   = sfp_pkg::PH_LEN;
                end
            end
            sfp_pkg::PH_LEN: begin
                if (in_acc) begin
                    if (i_len_ok) begin
                        n_length  = i_rx_byte[sfp_pkg::SIZE_W-1:0];
                        n_count   = '0;
                        n_sum_one = sum_one_add;
                        n_sum_two = r_sum_two + sum_one_add;
                        n_phase   = sfp_pkg::PH_PAY;
                    end else begin
                        n_phase = sfp_pkg::PH_HUNT;
                    end
                end
            end
            sfp_pkg::PH_PAY: begin
                if (in_acc) begin
                    o_mem_we  = 1'b1;
                    n_count   = cnt_inc[sfp_pkg::SIZE_W-1:0];
                    n_sum_one = sum_one_add;
                    n_sum_two = r_sum_two + sum_one_add;
                    if (cnt_inc >= {1'b0, r_length}) begin
                        n_phase = sfp_pkg::PH_SUM1;
                    end
                end
            end
            sfp_pkg::PH_SUM1: begin
                if (in_acc) begin
                    n_phase = (i_rx_byte == r_sum_one) ? sfp_pkg::PH_SUM2 : sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_SUM2: begin
                if (in_acc) begin
                    n_rd_idx = '0;
                    n_phase  = (i_rx_byte == r_sum_two) ? sfp_pkg::PH_RD : sfp_pkg::PH_HUNT;
                end
            end
            sfp_pkg::PH_RD: begin
                o_in_stall = 1'b1;
                o_mem_re   = 1'b1;
                n_phase    = sfp_pkg::PH_LOAD;
            end
            sfp_pkg::PH_LOAD: begin
                o_in_stall = 1'b1;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_rd_idx    = rd_inc[sfp_pkg::SIZE_W-1:0];
                    n_phase     = rd_last ? sfp_pkg::PH_HUNT : sfp_pkg::PH_RD;
                end
            end
            default: begin
                n_phase = sfp_pkg::PH_HUNT;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfp_pkg::PH_HUNT;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_id        <= '0;
            r_length    <= '0;
            r_sum_one   <= '0;
            r_sum_two   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_rd_idx    <= n_rd_idx;
            r_id        <= n_id;
            r_length    <= n_length;
            r_sum_one   <= n_sum_one;
            r_sum_two   <= n_sum_two;
            r_out_valid <= n_out_valid;
        end
    end

    // Load the result register from the store read data
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_id   <= r_id;
            r_out_idx  <= r_rd_idx[sfp_pkg::IDX_W-1:0];
            r_out_byte <= i_mem_rdata;
            r_out_last <= rd_last;
        end
    end

    assign o_cur_id       = r_id;
    assign o_mem_waddr    = AW'(r_count);
    assign o_mem_wdata    = i_rx_byte;
    assign o_mem_raddr    = AW'(r_rd_idx);
    assign o_out_valid    = r_out_valid;
    assign o_frame_id     = r_out_id;
    assign o_byte_index   = r_out_idx;
    assign o_payload_byte = r_out_byte;
    assign o_last_byte    = r_out_last;

    // Checks
    `SFP_ASSERT_NOW(a_pay_in_range, i_clk, i_rst_n, (r_phase == sfp_pkg::PH_PAY), (r_count < r_length), "payload write beyond frame length")
    `SFP_ASSERT_NOW(a_rd_in_range, i_clk, i_rst_n, ((r_phase == sfp_pkg::PH_RD) || (r_phase == sfp_pkg::PH_LOAD)), (r_rd_idx < r_length), "readout index beyond frame length")
    `SFP_ASSERT_NEXT(a_verified_starts_rd, i_clk, i_rst_n, (in_acc && (r_phase == sfp_pkg::PH_SUM2) && (i_rx_byte == r_sum_two)), ((r_phase == sfp_pkg::PH_RD) && (r_rd_idx == '0)), "verified frame did not start readout")
    `SFP_ASSERT_NEXT(a_last_ends_rd, i_clk, i_rst_n, (load && rd_last), ((r_phase == sfp_pkg::PH_HUNT) && r_out_valid && r_out_last), "last readout byte did not end the run")

endmodule

[hdl/sync_frame_parser_fletcher_check_top.sv]
// ----------------------------------------------------------------------------
// Sync frame parser with Fletcher check
// Hunts 0x55 0xAA, checks id and length against three kinds, stores the
// payload, verifies two modulo-256 sums and streams out the verified payload.
// ----------------------------------------------------------------------------
// Received bytes are accepted without stall while the parser hunts, reads the
// header, stores the payload or tests the two check bytes. After the second
// check byte of a verified frame the byte input stalls while the payload is
// streamed out of the store: each payload byte is first read from the store,
// then loaded into the result register once the output slot is free, and only
// then is the next byte read. Bytes that fail a check give no result. The
// store needs no clearing after reset; every entry read out was written
// earlier in the same frame.
module sync_frame_parser_fletcher_check_top #(
    parameter int MAX_PAYLOAD = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration
    input  logic                       i_cfg_we,
    input  logic [sfp_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [sfp_pkg::BYTE_W-1:0] i_cfg_wdata,
    // byte input
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [sfp_pkg::BYTE_W-1:0] i_rx_byte,
    // result output
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [sfp_pkg::BYTE_W-1:0] o_frame_id,
    output logic [sfp_pkg::IDX_W-1:0]  o_byte_index,
    output logic [sfp_pkg::BYTE_W-1:0] o_payload_byte,
    output logic                       o_last_byte
);

    localparam int AW = $clog2(MAX_PAYLOAD);

    logic [sfp_pkg::BYTE_W-1:0] cur_id;
    logic                       len_ok;
    logic                       mem_we;
    logic [AW-1:0]              mem_waddr;
    logic [sfp_pkg::BYTE_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [AW-1:0]              mem_raddr;
    logic [sfp_pkg::BYTE_W-1:0] mem_rdata;

    // Frame kind registers and length check
    sfp_cfg #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_id        (cur_id),
        .i_len       (i_rx_byte),
        .o_len_ok    (len_ok)
    );

    // Payload store
    sfp_store #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Parser and readout control
    sfp_ctrl #(
        .AW (AW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_cur_id       (cur_id),
        .i_len_ok       (len_ok),
        .o_mem_we       (mem_we),
        .o_mem_waddr    (mem_waddr),
        .o_mem_wdata    (mem_wdata),
        .o_mem_re       (mem_re),
        .o_mem_raddr    (mem_raddr),
        .i_mem_rdata    (mem_rdata),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_frame_id     (o_frame_id),
        .o_byte_index   (o_byte_index),
        .o_payload_byte (o_payload_byte),
        .o_last_byte    (o_last_byte)
    );

endmodule
